// ===== rtl/rational_round_to_fixed_denominator_assert.svh =====
// assertion helpers shared by the rrtfd modules
`ifndef RATIONAL_ROUND_TO_FIXED_DENOMINATOR_ASSERT_SVH
`define RATIONAL_ROUND_TO_FIXED_DENOMINATOR_ASSERT_SVH

// checked outside reset
`define RRTFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define RRTFD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rrtfd_pkg.sv =====
`default_nettype none

package rrtfd_pkg;

   typedef enum logic [1:0] {
      MODE_UP   = 2'd0,
      MODE_DOWN = 2'd1,
      MODE_NEAR = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_DEN = 2'd1,
      STATUS_SAT      = 2'd2
   } status_type;

   localparam int MODE_BITS      = 2;
   localparam int STATUS_BITS    = 2;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE   = 1'b1;

   typedef struct packed {
      logic advance;
      logic valid;
   } div_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/rrtfd_req_if.sv =====
`default_nettype none

interface rrtfd_req_if #(
   parameter int VALUE_BITS = 31
) ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] numerator_in;
   logic [VALUE_BITS-1:0] denominator_in;

   modport source (output valid, output numerator_in, output denominator_in, input ready);
   modport sink   (input valid, input numerator_in, input denominator_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/rrtfd_rsp_if.sv =====
`default_nettype none

interface rrtfd_rsp_if #(
   parameter int VALUE_BITS = 31
) ();
   import rrtfd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [VALUE_BITS-1:0]  rounded_numerator;
   logic [STATUS_BITS-1:0] status;

   modport source (output valid, output rounded_numerator, output status, input ready);
   modport sink   (input valid, input rounded_numerator, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/rrtfd_div.sv =====
`default_nettype none
`include "rational_round_to_fixed_denominator_assert.svh"

// restoring divider, one quotient bit per register stage
module rrtfd_div #(
   parameter int VALUE_BITS = 31
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire rrtfd_pkg::div_ctl_type    ctl,
   input  wire logic [2*VALUE_BITS-1:0]   dividend,
   input  wire logic [VALUE_BITS-1:0]     divisor,
   output logic                           valid_out,
   output logic [2*VALUE_BITS-1:0]        quotient,
   output logic [VALUE_BITS-1:0]          remainder,
   output logic [VALUE_BITS-1:0]          divisor_out
);
   import rrtfd_pkg::*;

   localparam int STEPS = 2 * VALUE_BITS;
   localparam int RQ_BITS = 3 * VALUE_BITS;

   // upper part: partial remainder, lower part: dividend shifting out, quotient shifting in
   logic [RQ_BITS-1:0]    rq_ff  [STEPS];
   logic [VALUE_BITS-1:0] dv_ff  [STEPS];
   logic [STEPS-1:0]      v_ff;

   logic [RQ_BITS-1:0]    rq_src [STEPS];
   logic [VALUE_BITS-1:0] dv_src [STEPS];
   logic [RQ_BITS-1:0]    rq_in  [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [VALUE_BITS:0]   trial;
      logic [VALUE_BITS+1:0] diff;
      logic                  qbit;

      if (k == 0) begin : g_first
         assign rq_src[k] = {{VALUE_BITS{1'b0}}, dividend};
         assign dv_src[k] = divisor;
      end else begin : g_next
         assign rq_src[k] = rq_ff[k-1];
         assign dv_src[k] = dv_ff[k-1];
      end

      assign trial = rq_src[k][RQ_BITS-1:2*VALUE_BITS-1];
      assign diff  = {1'b0, trial} - {2'b00, dv_src[k]};
      // no borrow means the divisor fits
      assign qbit  = ~diff[VALUE_BITS+1];
      assign rq_in[k] = {(qbit ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0]),
                         rq_src[k][2*VALUE_BITS-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (ctl.advance) begin
         v_ff <= {v_ff[STEPS-2:0], ctl.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         for (int k = 0; k < STEPS; k++) begin
            rq_ff[k] <= rq_in[k];
            dv_ff[k] <= dv_src[k];
         end
      end
   end

   assign valid_out   = v_ff[STEPS-1];
   assign quotient    = rq_ff[STEPS-1][2*VALUE_BITS-1:0];
   assign remainder   = rq_ff[STEPS-1][RQ_BITS-1:2*VALUE_BITS];
   assign divisor_out = dv_ff[STEPS-1];

   `RRTFD_ASSERT(a_rem_below_div, clock, reset, (valid_out && divisor_out != '0) |-> (remainder < divisor_out), "remainder not below divisor")
   `RRTFD_ASSERT_ALWAYS(a_reset_clears, clock, $past(reset) |-> !valid_out, "divider valid survives reset")
   `RRTFD_ASSERT(a_stall_holds, clock, reset, (!$past(ctl.advance) && !$past(reset)) |-> ($stable(quotient) && $stable(valid_out)), "divider moved while stalled")

endmodule

`default_nettype wire

// ===== rtl/rational_round_to_fixed_denominator.sv =====
`default_nettype none
`include "rational_round_to_fixed_denominator_assert.svh"

// channel   dir   beat contents                           handshake
// req_if    in    numerator_in, denominator_in            valid / ready
// rsp_if    out   rounded_numerator, status               valid / ready
// csr_*     in    csr_index, csr_wdata                    csr_we, no wait
//
// one beat per cycle in and out while the skid register is empty and the sink takes results;
// the divider retires one quotient bit per stage
// reset is synchronous; it clears valid bits and the registers to target 1, mode nearest
// a result the sink does not take parks in a skid register; the pipeline halts only
// when both output and skid are full, and req_if.ready comes straight from a flop

module rational_round_to_fixed_denominator #(
   parameter int VALUE_BITS = 31
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   rrtfd_req_if.sink                                  req_if,
   rrtfd_rsp_if.source                                rsp_if,
   input  wire logic                                  csr_we,
   input  wire logic [rrtfd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [VALUE_BITS-1:0]                 csr_wdata
);
   import rrtfd_pkg::*;

   localparam int WIDE = 2 * VALUE_BITS;

   // configuration
   logic [VALUE_BITS-1:0] target_ff;
   logic [MODE_BITS-1:0]  mode_ff;

   logic advance;

   // stage 1: input capture
   logic                  v1_ff;
   logic [VALUE_BITS-1:0] n1_ff, d1_ff;
   // stage 2: product
   logic                  v2_ff;
   logic [WIDE-1:0]       p2_ff, p2_in;
   logic [VALUE_BITS-1:0] d2_ff;
   // divider out
   div_ctl_type           div_ctl;
   logic                  dv_valid;
   logic [WIDE-1:0]       dv_quot;
   logic [VALUE_BITS-1:0] dv_rem, dv_den;
   // stage 3: ceiling
   logic                  v3_ff, rnz3_ff, qz3_ff;
   logic [WIDE-1:0]       c3_ff, c3_in, q3_ff;
   logic [VALUE_BITS-1:0] r3_ff, d3_ff;
   // stage 4: bounds and distances
   logic                  v4_ff, dz4_ff, near_lb4_ff, near_lb4_in;
   logic [WIDE-1:0]       ub4_ff, ub4_in, lb4_ff, lb4_in;
   logic                  pull;
   logic [VALUE_BITS-1:0] d_minus_r, a_lb, a_ub;
   // stage 5: mode select
   logic                  v5_ff, dz5_ff;
   logic [WIDE-1:0]       r5_ff, r5_in;
   // final
   logic                  sat;
   logic [VALUE_BITS-1:0] fin_value;
   logic [STATUS_BITS-1:0] fin_status;
   // output and skid
   logic                  out_valid_ff, skid_valid_ff;
   logic [VALUE_BITS-1:0] out_value_ff, skid_value_ff;
   logic [STATUS_BITS-1:0] out_status_ff, skid_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= VALUE_BITS'(1);
         mode_ff   <= MODE_NEAR;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET: target_ff <= csr_wdata;
            CSR_MODE:   mode_ff   <= csr_wdata[MODE_BITS-1:0];
            default:    ;
         endcase
      end
   end

   assign advance      = !skid_valid_ff;
   assign req_if.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_if.valid;
         v2_ff <= v1_ff;
         v3_ff <= dv_valid;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   assign p2_in = WIDE'(n1_ff) * WIDE'(target_ff);

   assign div_ctl.advance = advance;
   assign div_ctl.valid   = v2_ff;

   rrtfd_div #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .ctl         (div_ctl),
      .dividend    (p2_ff),
      .divisor     (d2_ff),
      .valid_out   (dv_valid),
      .quotient    (dv_quot),
      .remainder   (dv_rem),
      .divisor_out (dv_den)
   );

   assign c3_in = dv_quot + WIDE'(dv_rem != '0);

   always_comb begin
      pull      = (c3_ff == {{VALUE_BITS{1'b0}}, target_ff}) && (c3_ff != '0);
      ub4_in    = pull ? (c3_ff - WIDE'(1)) : c3_ff;
      lb4_in    = qz3_ff ? WIDE'(1) : q3_ff;
      d_minus_r = d3_ff - r3_ff;
      // distances to the input value, scaled by the target denominator times the input denominator
      a_lb      = qz3_ff ? d_minus_r : r3_ff;
      if (pull) begin
         a_ub = rnz3_ff ? r3_ff : d3_ff;
      end else begin
         a_ub = rnz3_ff ? d_minus_r : '0;
      end
      near_lb4_in = a_lb < a_ub;
   end

   always_comb begin
      case (mode_ff)
         MODE_UP:   r5_in = ub4_ff;
         MODE_DOWN: r5_in = lb4_ff;
         default:   r5_in = near_lb4_ff ? lb4_ff : ub4_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n1_ff       <= req_if.numerator_in;
         d1_ff       <= req_if.denominator_in;
         p2_ff       <= p2_in;
         d2_ff       <= d1_ff;
         c3_ff       <= c3_in;
         q3_ff       <= dv_quot;
         r3_ff       <= dv_rem;
         d3_ff       <= dv_den;
         rnz3_ff     <= dv_rem != '0;
         qz3_ff      <= dv_quot == '0;
         ub4_ff      <= ub4_in;
         lb4_ff      <= lb4_in;
         near_lb4_ff <= near_lb4_in;
         dz4_ff      <= d3_ff == '0;
         r5_ff       <= r5_in;
         dz5_ff      <= dz4_ff;
      end
   end

   always_comb begin
      sat = |r5_ff[WIDE-1:VALUE_BITS];
      if (dz5_ff) begin
         fin_value  = '0;
         fin_status = STATUS_ZERO_DEN;
      end else if (sat) begin
         fin_value  = '1;
         fin_status = STATUS_SAT;
      end else begin
         fin_value  = r5_ff[VALUE_BITS-1:0];
         fin_status = STATUS_OK;
      end
   end

   // output register with skid behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_if.ready) begin
         out_valid_ff  <= skid_valid_ff || v5_ff;
         skid_valid_ff <= 1'b0;
      end else if (v5_ff && advance) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_if.ready) begin
         out_value_ff  <= skid_valid_ff ? skid_value_ff : fin_value;
         out_status_ff <= skid_valid_ff ? skid_status_ff : fin_status;
      end else if (advance) begin
         skid_value_ff  <= fin_value;
         skid_status_ff <= fin_status;
      end
   end

   assign rsp_if.valid             = out_valid_ff;
   assign rsp_if.rounded_numerator = out_value_ff;
   assign rsp_if.status            = out_status_ff;

   `RRTFD_ASSERT(a_skid_behind_out, clock, reset, skid_valid_ff |-> out_valid_ff, "skid holds a beat while output is empty")
   `RRTFD_ASSERT(a_skid_only_on_stall, clock, reset, $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_if.ready), "skid filled without an output stall")
   `RRTFD_ASSERT(a_zero_den_value, clock, reset, (rsp_if.valid && rsp_if.status == STATUS_ZERO_DEN) |-> (rsp_if.rounded_numerator == '0), "zero denominator with nonzero result")

endmodule

`default_nettype wire

// ===== test/tb_rational_round_to_fixed_denominator.sv =====
`default_nettype none

module tb_rational_round_to_fixed_denominator;
   import rrtfd_pkg::*;

   localparam int VALUE_BITS = 31;
   localparam bit [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
   localparam bit [MODE_BITS-1:0] MODE_SPARE = 2'd3;
   localparam int PHASES = 12;
   localparam int PHASE_ITEMS = 108;
   localparam int PRESSURE_PHASE = 9;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      bit [VALUE_BITS-1:0] rounded;
      status_type          status;
   } rounding_result_type;

   class rounding_scoreboard_type;
      bit [VALUE_BITS-1:0] target;
      bit [MODE_BITS-1:0]  mode;
      rounding_result_type owed_roundings[$];
      int unsigned         mismatches;

      function new();
         target = 1;
         mode = MODE_NEAR;
         mismatches = 0;
      endfunction

      function void set_config(bit [VALUE_BITS-1:0] new_target, bit [MODE_BITS-1:0] new_mode);
         target = new_target;
         mode = new_mode;
      endfunction

      function int outstanding();
         return owed_roundings.size();
      endfunction

      function bit [63:0] ceil_steps(bit [63:0] prod, bit [VALUE_BITS-1:0] den);
         bit [63:0] q;
         q = prod / 64'(den);
         if (prod % 64'(den) != 0) q++;
         // a full step is pulled back below the target
         if (q == 64'(target) && q != 0) q--;
         return q;
      endfunction

      function bit [63:0] floor_steps(bit [63:0] prod, bit [VALUE_BITS-1:0] den);
         bit [63:0] q;
         q = prod / 64'(den);
         if (q == 0) q = 1;
         return q;
      endfunction

      function bit [63:0] distance(bit [63:0] a, bit [63:0] b);
         return (a > b) ? a - b : b - a;
      endfunction

      function rounding_result_type predict(bit [VALUE_BITS-1:0] num, bit [VALUE_BITS-1:0] den);
         rounding_result_type res;
         bit [63:0] prod, lo, hi, pick;
         if (den == 0) begin
            res.rounded = 0;
            res.status = STATUS_ZERO_DEN;
            return res;
         end
         prod = 64'(num) * 64'(target);
         hi = ceil_steps(prod, den);
         lo = floor_steps(prod, den);
         case (mode)
            MODE_UP:   pick = hi;
            MODE_DOWN: pick = lo;
            default: begin
               // exact comparison of lo/t and hi/t against num/den
               pick = (distance(lo * 64'(den), prod) < distance(hi * 64'(den), prod)) ? lo : hi;
            end
         endcase
         if (pick > 64'(VALUE_MAX)) begin
            res.rounded = VALUE_MAX;
            res.status = STATUS_SAT;
         end else begin
            res.rounded = pick[VALUE_BITS-1:0];
            res.status = STATUS_OK;
         end
         return res;
      endfunction

      function void note_fraction(bit [VALUE_BITS-1:0] num, bit [VALUE_BITS-1:0] den);
         owed_roundings.push_back(predict(num, den));
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("mismatch: %s got %0d expected %0d", what, got, want);
         mismatches++;
      endtask

      task check_result(logic [VALUE_BITS-1:0] rounded, logic [STATUS_BITS-1:0] status);
         rounding_result_type want;
         if (owed_roundings.size() == 0) begin
            report_mismatch("unexpected beat, rounded_numerator", longint'(rounded), -1);
            return;
         end
         want = owed_roundings.pop_front();
         if (rounded !== want.rounded)
            report_mismatch("rounded_numerator", longint'(rounded), longint'(want.rounded));
         if (status !== want.status)
            report_mismatch("status", longint'(status), longint'(want.status));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [VALUE_BITS-1:0] csr_wdata;

   int unsigned send_idle_pct = 20;
   int unsigned recv_idle_pct = 68;
   bit hold_pending = 1'b0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   bit [VALUE_BITS-1:0] cur_target = 1;

   rounding_scoreboard_type rounding_board = new();

   rrtfd_req_if #(.VALUE_BITS(VALUE_BITS)) req ();
   rrtfd_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp ();

   rational_round_to_fixed_denominator #(.VALUE_BITS(VALUE_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req),
      .rsp_if    (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rational_round_to_fixed_denominator regression: fail");
         $finish;
      end
   end

   // result side: check accepted beats, stall at random or for a long hold
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            rounding_board.check_result(rsp.rounded_numerator, rsp.status);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_fraction(input bit [VALUE_BITS-1:0] num, input bit [VALUE_BITS-1:0] den);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req.valid <= 1'b0;
         req.numerator_in <= VALUE_BITS'($urandom);
         req.denominator_in <= VALUE_BITS'($urandom);
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.numerator_in <= num;
      req.denominator_in <= den;
      do @(posedge clock); while (req.ready !== 1'b1);
      rounding_board.note_fraction(num, den);
   endtask

   task automatic wait_drained();
      while (rounding_board.outstanding() != 0) @(posedge clock);
   endtask

   task automatic configure(input bit [VALUE_BITS-1:0] target, input bit [MODE_BITS-1:0] mode);
      bit [VALUE_BITS-1:0] mode_word;
      // bits above the mode field carry noise
      mode_word = {(VALUE_BITS - MODE_BITS)'($urandom), mode};
      csr_we <= 1'b1;
      csr_index <= CSR_TARGET;
      csr_wdata <= target;
      @(posedge clock);
      csr_index <= CSR_MODE;
      csr_wdata <= mode_word;
      @(posedge clock);
      csr_we <= 1'b0;
      rounding_board.set_config(target, mode);
      cur_target = target;
   endtask

   function automatic bit [VALUE_BITS-1:0] phase_target(input int ph);
      if (ph == 0) return VALUE_MAX;
      if (ph == 1) return 1;
      case ($urandom_range(0, 6))
         0: return 2;
         1: return 3;
         2: return VALUE_BITS'($urandom_range(1, 16));
         3: return VALUE_BITS'($urandom_range(1, 65535));
         4: return VALUE_BITS'($urandom);
         5: return 0;
         default: return VALUE_MAX - VALUE_BITS'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic bit [MODE_BITS-1:0] phase_mode(input int ph);
      case (ph % 4)
         0: return MODE_UP;
         1: return MODE_DOWN;
         2: return MODE_NEAR;
         default: return MODE_SPARE;
      endcase
   endfunction

   task automatic pick_fraction(output bit [VALUE_BITS-1:0] num, output bit [VALUE_BITS-1:0] den);
      case ($urandom_range(0, 9))
         0: begin
            num = VALUE_BITS'($urandom);
            den = 0;
         end
         1: begin
            num = VALUE_BITS'($urandom_range(0, 20));
            den = VALUE_BITS'($urandom_range(1, 20));
         end
         2: begin
            num = VALUE_BITS'($urandom);
            den = VALUE_BITS'($urandom);
         end
         3: begin
            num = VALUE_BITS'($urandom);
            den = VALUE_BITS'($urandom_range(1, 255));
         end
         4: begin
            den = VALUE_BITS'($urandom_range(1, VALUE_MAX));
            num = den;
         end
         5: begin
            // odd multiple of half a step: exact tie between neighbors
            if (cur_target != 0 && cur_target < (VALUE_MAX >> 1)) begin
               den = cur_target << 1;
               num = VALUE_BITS'(2 * $urandom_range(0, 1000) + 1);
            end else begin
               den = VALUE_BITS'($urandom_range(1, 7)) << 1;
               num = VALUE_BITS'($urandom_range(0, 64));
            end
         end
         default: begin
            num = VALUE_BITS'($urandom) >> $urandom_range(0, VALUE_BITS - 1);
            den = VALUE_BITS'($urandom) >> $urandom_range(0, VALUE_BITS - 1);
         end
      endcase
   endtask

   initial begin
      bit [VALUE_BITS-1:0] num, den;
      req.valid = 1'b0;
      req.numerator_in = '0;
      req.denominator_in = '0;
      csr_we = 1'b0;
      csr_index = CSR_TARGET;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // register values straight out of reset: target one, nearest
      send_fraction(1, 2);
      send_fraction(5, 0);
      send_fraction(VALUE_MAX, VALUE_MAX);
      req.valid <= 1'b0;
      wait_drained();

      configure(VALUE_MAX, MODE_UP);
      send_fraction(VALUE_MAX, 1);
      send_fraction(0, 1);
      send_fraction(1, VALUE_MAX);
      send_fraction(VALUE_MAX, VALUE_MAX);
      send_fraction(0, 0);
      req.valid <= 1'b0;
      wait_drained();

      // zero target: down lifts to one, up stays at zero
      configure(0, MODE_DOWN);
      send_fraction(7, 3);
      send_fraction(VALUE_MAX, 1);
      req.valid <= 1'b0;
      wait_drained();
      configure(0, MODE_UP);
      send_fraction(7, 3);
      req.valid <= 1'b0;
      wait_drained();

      // spare mode code rounds to nearest, ties go up
      configure(4, MODE_SPARE);
      send_fraction(1, 8);
      send_fraction(3, 8);
      send_fraction(5, 16);
      send_fraction(VALUE_MAX, 2);
      req.valid <= 1'b0;
      wait_drained();

      configure(1000, MODE_DOWN);
      send_fraction(0, 5);
      send_fraction(2, 3);
      send_fraction(1, VALUE_MAX);
      send_fraction(VALUE_MAX, 3);
      req.valid <= 1'b0;
      wait_drained();

      configure(3, MODE_NEAR);
      send_fraction(1, 1);
      send_fraction(2, 3);
      req.valid <= 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         if (ph < PHASES / 3) begin
            send_idle_pct = 20;
            recv_idle_pct = 68;
         end else if (ph < 2 * PHASES / 3) begin
            send_idle_pct = 68;
            recv_idle_pct = 20;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         configure(phase_target(ph), phase_mode(ph));
         // long result stall so the pipeline fills and pushes back
         if (ph == PRESSURE_PHASE) hold_pending = 1'b1;
         repeat (PHASE_ITEMS) begin
            pick_fraction(num, den);
            send_fraction(num, den);
         end
         req.valid <= 1'b0;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rounding_board.mismatches == 0 && rounding_board.outstanding() == 0)
         $display("rational_round_to_fixed_denominator regression: pass");
      else
         $display("rational_round_to_fixed_denominator regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
